FILE: rtl/dedf_pkg.sv
`default_nettype none

package dedf_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_DELIMITER    = 2'd0;
    localparam logic [1:0] REG_ESCAPE       = 2'd1;
    localparam logic [1:0] REG_CHECK_ENABLE = 2'd2;

    localparam logic [7:0] DELIMITER_RESET = 8'd16;
    localparam logic [7:0] ESCAPE_RESET    = 8'd27;

    localparam logic [7:0] BIT5_MASK = 8'h20;

    // Default depth of the token queue between the front and the back.
    localparam int TOKEN_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_FRAME,
        MODE_HUNT,
        MODE_HUNT_DELIM
    } t_link_mode;

    typedef enum logic {
        TOK_DATA,
        TOK_CLOSE
    } t_tok_kind;

    // One classified word handed from the front to the back.
    typedef struct packed {
        t_tok_kind  kind;
        logic [7:0] data;
    } t_token;

    // Configuration seen by the front.
    typedef struct packed {
        logic [7:0] delimiter;
        logic [7:0] escape;
    } t_front_cfg;

endpackage

`default_nettype wire

FILE: rtl/dedf_front.sv
`default_nettype none

module dedf_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire                 i_ready,
    input  wire  [7:0]          i_rx_byte,
    input  dedf_pkg::t_front_cfg i_cfg,
    output logic                o_push,
    output dedf_pkg::t_token    o_token
);

    dedf_pkg::t_link_mode r_mode, n_mode;
    logic                 r_esc_pending, n_esc_pending;
    logic                 w_accept;
    logic                 w_is_delim;
    logic                 w_is_escape;

    assign w_accept    = i_valid && i_ready;
    assign w_is_delim  = (i_rx_byte == i_cfg.delimiter);
    assign w_is_escape = (i_rx_byte == i_cfg.escape);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= dedf_pkg::MODE_IDLE;
            r_esc_pending <= 1'b0;
        end else begin
            r_mode        <= n_mode;
            r_esc_pending <= n_esc_pending;
        end
    end

    always_comb begin
        n_mode        = r_mode;
        n_esc_pending = r_esc_pending;
        o_push        = 1'b0;
        o_token.kind  = dedf_pkg::TOK_DATA;
        o_token.data  = r_esc_pending ? (i_rx_byte ^ dedf_pkg::BIT5_MASK) : i_rx_byte;
        if (w_accept) begin
            unique case (r_mode)
                dedf_pkg::MODE_IDLE, dedf_pkg::MODE_HUNT_DELIM: begin
                    n_esc_pending = 1'b0;
                    n_mode = w_is_delim ? dedf_pkg::MODE_FRAME : dedf_pkg::MODE_HUNT;
                end
                dedf_pkg::MODE_HUNT: begin
                    n_mode = w_is_delim ? dedf_pkg::MODE_HUNT_DELIM : dedf_pkg::MODE_HUNT;
                end
                dedf_pkg::MODE_FRAME: begin
                    if (w_is_delim) begin
                        // A pending escape before the closing delimiter is dropped.
                        o_push        = 1'b1;
                        o_token.kind  = dedf_pkg::TOK_CLOSE;
                        n_esc_pending = 1'b0;
                        n_mode        = dedf_pkg::MODE_IDLE;
                    end else if (!r_esc_pending && w_is_escape) begin
                        n_esc_pending = 1'b1;
                    end else begin
                        o_push        = 1'b1;
                        n_esc_pending = 1'b0;
                    end
                end
                default: begin
                    n_mode = dedf_pkg::MODE_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dedf_queue.sv
`default_nettype none

module dedf_queue #(
    parameter int DEPTH = dedf_pkg::TOKEN_QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  dedf_pkg::t_token i_token,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_empty,
    output dedf_pkg::t_token o_token
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dedf_pkg::t_token r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_token   = r_slot[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_token;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dedf_back.sv
`default_nettype none

module dedf_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_check_enable,
    input  wire              i_tok_avail,
    input  dedf_pkg::t_token i_token,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [7:0]       o_data_byte,
    output logic             o_last,
    output logic             o_empty_frame,
    output logic             o_check_ok,
    output logic [31:0]      o_good_frames
);

    logic        r_valid, n_valid;
    logic [7:0]  r_data, n_data;
    logic        r_last, n_last;
    logic        r_empty, n_empty;
    logic        r_ok, n_ok;
    logic [31:0] r_good_count, n_good_count;
    logic [7:0]  r_held, n_held;
    logic        r_held_valid, n_held_valid;
    logic [7:0]  r_sum, n_sum;
    logic        w_match;

    // A token is popped whenever the output register is free or being drained.
    assign o_pop   = i_tok_avail && (!r_valid || i_ready);
    assign w_match = i_check_enable && (r_sum == r_held);

    always_comb begin
        n_valid      = r_valid && !i_ready;
        n_data       = r_data;
        n_last       = r_last;
        n_empty      = r_empty;
        n_ok         = r_ok;
        n_good_count = r_good_count;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_sum        = r_sum;
        if (o_pop) begin
            case (i_token.kind)
                dedf_pkg::TOK_CLOSE: begin
                    n_valid      = 1'b1;
                    n_last       = 1'b1;
                    n_data       = r_held_valid ? r_held : 8'd0;
                    n_empty      = !r_held_valid;
                    n_ok         = r_held_valid && w_match;
                    if (r_held_valid && w_match) begin
                        n_good_count = r_good_count + 32'd1;
                    end
                    n_held       = 8'd0;
                    n_held_valid = 1'b0;
                    n_sum        = 8'd0;
                end
                default: begin
                    if (r_held_valid) begin
                        n_valid = 1'b1;
                        n_data  = r_held;
                        n_last  = 1'b0;
                        n_empty = 1'b0;
                        n_ok    = 1'b0;
                        n_sum   = r_sum + r_held;
                    end
                    n_held       = i_token.data;
                    n_held_valid = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_good_count <= 32'd0;
            r_held       <= 8'd0;
            r_held_valid <= 1'b0;
            r_sum        <= 8'd0;
        end else begin
            r_valid      <= n_valid;
            r_good_count <= n_good_count;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_sum        <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_last  <= n_last;
        r_empty <= n_empty;
        r_ok    <= n_ok;
    end

    assign o_valid       = r_valid;
    assign o_data_byte   = r_data;
    assign o_last        = r_last;
    assign o_empty_frame = r_empty;
    assign o_check_ok    = r_ok;
    assign o_good_frames = r_good_count;

`ifndef SYNTHESIS
    a_empty_is_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_empty) |-> (r_last && !r_ok && (r_data == 8'd0)))
        else $error("empty frame word is malformed");

    a_ok_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_ok) |-> r_last)
        else $error("checksum flag on a word that is not last");

    a_close_clears_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_token.kind == dedf_pkg::TOK_CLOSE))
        |=> (!r_held_valid && (r_sum == 8'd0)))
        else $error("frame state not cleared after close");

    a_count_moves_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !(i_token.kind == dedf_pkg::TOK_CLOSE)) |=> $stable(r_good_count))
        else $error("good frame count changed on a data word");
`endif

endmodule

`default_nettype wire

FILE: rtl/byte_stuffed_frame_deframer_top.sv
// Byte-stuffed frame deframer with an additive checksum.
//
// Received bytes enter on the slave stream, one word per byte. The front
// classifies each byte against the delimiter and escape registers and queues
// decoded payload bytes and frame closes; the back holds each decoded byte
// until the next one (or the close) arrives, keeps the running 8-bit sum and
// the good-frame count, and drives the master stream.
// The master word carries the decoded byte and the good-frame count in tdata,
// the last flag in tlast, and the empty-frame and checksum flags in tuser.
// Throughput is one byte per cycle while the token queue has room. A payload
// byte is given out after the byte that follows it (or the closing delimiter)
// is accepted: that token enters the queue, and when it is popped (nothing
// older queued, output free or draining) the held byte moves to the output.
// When the receiver stalls, the output register holds its word, the token queue
// (four words by default) fills, then tready drops until a word is taken.
// Reset (synchronous, active low) loads the delimiter 16, escape 27 and
// checking off, clears the frame state and the good-frame count, and empties
// the queue. Configuration writes take effect at the next clock edge; the user
// makes them while the block is idle, which the block itself does not enforce.
`default_nettype none

module byte_stuffed_frame_deframer_top #(
    parameter int QUEUE_DEPTH = dedf_pkg::TOKEN_QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write port.
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [7:0]  i_cfg_data,
    // Received bytes.
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    // Decoded words.
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [7:0] data_byte, [39:8] good_frames
    output logic        o_m_axis_tlast,
    output logic [1:0]  o_m_axis_tuser    // [0] empty_frame, [1] check_ok
);

    logic [7:0]           r_delimiter;
    logic [7:0]           r_escape;
    logic                 r_check_enable;
    dedf_pkg::t_front_cfg w_front_cfg;
    logic                 w_push;
    dedf_pkg::t_token     w_push_token;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_pop;
    dedf_pkg::t_token     w_head_token;
    logic [7:0]           w_data_byte;
    logic [31:0]          w_good_frames;
    logic                 w_empty_frame;
    logic                 w_check_ok;

    // Configuration registers; an index past the last register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delimiter    <= dedf_pkg::DELIMITER_RESET;
            r_escape       <= dedf_pkg::ESCAPE_RESET;
            r_check_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dedf_pkg::REG_DELIMITER:    r_delimiter    <= i_cfg_data;
                dedf_pkg::REG_ESCAPE:       r_escape       <= i_cfg_data;
                dedf_pkg::REG_CHECK_ENABLE: r_check_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_front_cfg.delimiter = r_delimiter;
    assign w_front_cfg.escape    = r_escape;

    // The front only pushes when the queue has room, so ready is simply not full.
    assign o_s_axis_tready = !w_full;

    dedf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_ready   (o_s_axis_tready),
        .i_rx_byte (i_s_axis_tdata),
        .i_cfg     (w_front_cfg),
        .o_push    (w_push),
        .o_token   (w_push_token)
    );

    dedf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_token (w_push_token),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_token (w_head_token)
    );

    dedf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_check_enable (r_check_enable),
        .i_tok_avail    (!w_empty),
        .i_token        (w_head_token),
        .o_pop          (w_pop),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_data_byte    (w_data_byte),
        .o_last         (o_m_axis_tlast),
        .o_empty_frame  (w_empty_frame),
        .o_check_ok     (w_check_ok),
        .o_good_frames  (w_good_frames)
    );

    assign o_m_axis_tdata = {w_good_frames, w_data_byte};
    assign o_m_axis_tuser = {w_check_ok, w_empty_frame};

endmodule

`default_nettype wire
